// ----- sv/cfd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the conference frame deframer: event codes,
// field widths and the bit masks of the command byte.
// ---------------------------------------------------------------------------
package cfd_pkg;

   localparam int unsigned ByteW      = 8;
   localparam int unsigned AddrW      = 16;
   localparam int unsigned EventW     = 3;
   localparam int unsigned RspDataW   = 56;

   // command low five bits all ones marks a special frame
   localparam logic [4:0] SpecialMark = 5'h1f;

   // command flag bit positions
   localparam int unsigned CmdEndstationBit = 7;
   localparam int unsigned CmdInitiativeBit = 6;
   localparam int unsigned CmdPresidentBit  = 5;

   // result event codes
   typedef enum logic [EventW-1:0] {
      EV_NORMAL_DONE  = 3'd0,
      EV_PAYLOAD      = 3'd1,
      EV_SPECIAL_DONE = 3'd2,
      EV_WRONG_GUIDE  = 3'd3,
      EV_TRUNCATED    = 3'd4
   } event_type;

endpackage : cfd_pkg
`default_nettype wire

// ----- sv/conference_frame_deframer_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// conference_frame_deframer_core
// Byte-stream deframer for terminal-to-host frames: tracks header, special
// payload and check byte, streams out special payload bytes and reports
// frame completion, wrong guide bytes and truncated frames.
// ---------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------
//  req_    | in        | one received byte, start mark (tuser), last (tlast)
//  rsp_    | out       | event code (tuser), header, data, length, flags
//  csr_    | in        | expected guide byte, write only
//
//  one byte is accepted per cycle unless a result waits untaken; its result,
//  if any, appears on rsp_ in the next cycle from the result register.
//  the frame tracker and the result register sit back to back, so a stalled
//  rsp_ side holds req_tready low only while a result waits untaken.
//  reset is synchronous and returns the tracker to idle with empty holds.
//  frame_type resets to zero.
//
module conference_frame_deframer_core
   import cfd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration
   input  wire logic                 csr_wr_en,
   input  wire logic [ByteW-1:0]     csr_wr_data,   // frame_type
   // byte stream in
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteW-1:0]     req_tdata,     // [7:0] data_byte
   input  wire logic                 req_tuser,     // [0] start_of_frame
   input  wire logic                 req_tlast,     // last_in_buffer
   // results out
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // [7:0] guide_byte, [15:8] command_byte, [31:16] address,
   // [39:32] data_value, [47:40] payload_length, [48] checksum_ok,
   // [49] from_endstation, [50] initiative, [51] from_president, [55:52] zero
   output logic [RspDataW-1:0]       rsp_tdata,
   output logic [EventW-1:0]         rsp_tuser      // [2:0] event_res
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CMD     = 3'd1,
      PH_ADDR_HI = 3'd2,
      PH_ADDR_LO = 3'd3,
      PH_DATA    = 3'd4,
      PH_LEN     = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_CHECK   = 3'd7
   } phase_type;

   // state
   logic [ByteW-1:0]  frame_type_ff;
   phase_type         phase_ff, phase_in;
   logic              special_ff, special_in;
   logic [ByteW-1:0]  guide_ff, guide_in;
   logic [ByteW-1:0]  command_ff, command_in;
   logic [AddrW-1:0]  address_ff, address_in;
   logic [ByteW-1:0]  data_ff, data_in;
   logic [ByteW-1:0]  length_ff, length_in;
   logic [ByteW-1:0]  remain_ff, remain_in;
   logic [ByteW-1:0]  xor_ff, xor_in;

   // result register
   logic                 rsp_valid_ff;
   logic [RspDataW-1:0]  rsp_data_ff, rsp_data_in;
   event_type            rsp_event_ff, rsp_event_in;

   // per-beat working values
   logic              req_fire;
   logic [ByteW-1:0]  in_byte;
   phase_type         ph_nx;
   logic              spec_nx;
   logic [ByteW-1:0]  guide_nx, command_nx, data_nx, length_nx, remain_nx, xor_nx;
   logic [AddrW-1:0]  address_nx;
   logic              emit;
   event_type         ev;
   logic [ByteW-1:0]  dval;
   logic [ByteW-1:0]  plen;
   logic              ok;
   logic              trunc_chk;
   logic              clear;

   assign in_byte    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // frame tracking for one beat
   always_comb begin
      ph_nx      = phase_ff;
      spec_nx    = special_ff;
      guide_nx   = guide_ff;
      command_nx = command_ff;
      address_nx = address_ff;
      data_nx    = data_ff;
      length_nx  = length_ff;
      remain_nx  = remain_ff;
      xor_nx     = xor_ff;
      emit       = 1'b0;
      ev         = EV_NORMAL_DONE;
      dval       = '0;
      plen       = '0;
      ok         = 1'b0;
      trunc_chk  = 1'b0;
      clear      = 1'b0;

      if (req_tuser) begin
         // start mark drops any frame in progress
         spec_nx    = 1'b0;
         command_nx = '0;
         address_nx = '0;
         data_nx    = '0;
         length_nx  = '0;
         remain_nx  = '0;
         guide_nx   = in_byte;
         if (in_byte != frame_type_ff) begin
            xor_nx = '0;
            emit   = 1'b1;
            ev     = EV_WRONG_GUIDE;
            clear  = 1'b1;
         end else begin
            xor_nx    = in_byte;
            ph_nx     = PH_CMD;
            trunc_chk = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_CMD: begin
               command_nx = in_byte;
               spec_nx    = (in_byte[4:0] == SpecialMark);
               xor_nx     = xor_ff ^ in_byte;
               ph_nx      = PH_ADDR_HI;
               trunc_chk  = 1'b1;
            end
            PH_ADDR_HI: begin
               address_nx = {in_byte, {ByteW{1'b0}}};
               xor_nx     = xor_ff ^ in_byte;
               ph_nx      = PH_ADDR_LO;
               trunc_chk  = 1'b1;
            end
            PH_ADDR_LO: begin
               address_nx = {address_ff[AddrW-1:ByteW], in_byte};
               xor_nx     = xor_ff ^ in_byte;
               ph_nx      = special_ff ? PH_LEN : PH_DATA;
               trunc_chk  = 1'b1;
            end
            PH_DATA: begin
               data_nx   = in_byte;
               xor_nx    = xor_ff ^ in_byte;
               ph_nx     = PH_CHECK;
               trunc_chk = 1'b1;
            end
            PH_LEN: begin
               length_nx = in_byte;
               remain_nx = in_byte;
               xor_nx    = xor_ff ^ in_byte;
               ph_nx     = (in_byte != '0) ? PH_PAYLOAD : PH_CHECK;
               trunc_chk = 1'b1;
            end
            PH_PAYLOAD: begin
               data_nx   = in_byte;
               xor_nx    = xor_ff ^ in_byte;
               remain_nx = remain_ff - 1'b1;
               if (remain_nx == '0) begin
                  ph_nx = PH_CHECK;
               end
               if (!req_tlast) begin
                  emit = 1'b1;
                  ev   = EV_PAYLOAD;
                  dval = in_byte;
                  plen = length_ff;
               end
               trunc_chk = 1'b1;
            end
            PH_CHECK: begin
               emit  = 1'b1;
               ok    = (xor_ff == in_byte);
               ev    = special_ff ? EV_SPECIAL_DONE : EV_NORMAL_DONE;
               dval  = special_ff ? '0 : data_ff;
               plen  = special_ff ? length_ff : '0;
               clear = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // frame cut off by the end of the buffer
      if (trunc_chk && req_tlast) begin
         emit  = 1'b1;
         ev    = EV_TRUNCATED;
         dval  = data_nx;
         plen  = length_nx;
         ok    = 1'b0;
         clear = 1'b1;
      end
   end

   // result beat and next holds
   always_comb begin
      rsp_event_in = ev;
      rsp_data_in  = {4'b0000,
                      command_nx[CmdPresidentBit],
                      command_nx[CmdInitiativeBit],
                      command_nx[CmdEndstationBit],
                      ok, plen, dval, address_nx, command_nx, guide_nx};

      phase_in   = ph_nx;
      special_in = spec_nx;
      guide_in   = guide_nx;
      command_in = command_nx;
      address_in = address_nx;
      data_in    = data_nx;
      length_in  = length_nx;
      remain_in  = remain_nx;
      xor_in     = xor_nx;
      if (clear) begin
         phase_in   = PH_IDLE;
         special_in = 1'b0;
         guide_in   = '0;
         command_in = '0;
         address_in = '0;
         data_in    = '0;
         length_in  = '0;
         remain_in  = '0;
         xor_in     = '0;
      end
   end

   // state, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_type_ff <= '0;
         phase_ff      <= PH_IDLE;
         special_ff    <= 1'b0;
         guide_ff      <= '0;
         command_ff    <= '0;
         address_ff    <= '0;
         data_ff       <= '0;
         length_ff     <= '0;
         remain_ff     <= '0;
         xor_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frame_type_ff <= csr_wr_data;
         end
         if (req_fire) begin
            phase_ff     <= phase_in;
            special_ff   <= special_in;
            guide_ff     <= guide_in;
            command_ff   <= command_in;
            address_ff   <= address_in;
            data_ff      <= data_in;
            length_ff    <= length_in;
            remain_ff    <= remain_in;
            xor_ff       <= xor_in;
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_event_ff <= rsp_event_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_event_ff;

   // checks

   // an empty result register never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty result register");

   // a bad guide byte always sends the tracker back to idle
   a_wrong_guide_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser && (req_tdata != frame_type_ff)) |=> (phase_ff == PH_IDLE))
      else $error("tracker left idle after wrong guide");

   // payload phase always has bytes left to take
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != '0))
      else $error("payload phase with zero bytes remaining");

   // wrong guide beat carries only the guide byte
   a_wrong_guide_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_ff == EV_WRONG_GUIDE)) |->
         (rsp_data_ff[RspDataW-1:ByteW] == '0))
      else $error("wrong guide beat carries stale fields");

   // payload and truncated beats never claim a good check byte
   a_no_ok_midframe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_event_ff == EV_PAYLOAD) || (rsp_event_ff == EV_TRUNCATED))) |->
         !rsp_data_ff[48])
      else $error("checksum flag set on a non-completion beat");

endmodule : conference_frame_deframer_core
`default_nettype wire

// ----- dv/conference_frame_deframer_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conference_frame_deframer_core_test
// Self-checking bench for the frame deframer. A driver streams byte beats
// from a queue and a monitor takes result beats. Both sides idle at random.
// A frame tracker in the bench predicts each result as its byte is accepted,
// and the monitor compares every result field with the oldest prediction.
// The run steps through several expected guide values, the extremes among
// them. Each setting gets well formed frames, truncated frames, restarted
// frames, wrong guides and stray bytes.
// ---------------------------------------------------------------------------
module conference_frame_deframer_core_test;
   import cfd_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned PhaseBytes = 300;
   localparam int unsigned SettleCycles = 4;

   // tracker phases, one per frame field; idle waits for the guide byte
   typedef enum logic [2:0] {
      TRK_IDLE, TRK_CMD, TRK_ADDR_HI, TRK_ADDR_LO,
      TRK_DATA, TRK_LEN, TRK_PAYLOAD, TRK_CHECK
   } track_phase_type;

   // result tdata layout, msb first
   typedef struct packed {
      logic [3:0]       pad;
      logic             president;
      logic             initiative;
      logic             endstation;
      logic             check_ok;
      logic [7:0]       plen;
      logic [7:0]       dval;
      logic [AddrW-1:0] addr;
      logic [7:0]       command;
      logic [7:0]       guide;
   } rsp_fields_type;

   typedef struct packed {
      event_type      ev;
      rsp_fields_type f;
   } frame_report_type;

   typedef struct {
      logic [7:0]  data;
      logic        sof;
      logic        last;
      int unsigned gap;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [ByteW-1:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ByteW-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [EventW-1:0] rsp_tuser;

   conference_frame_deframer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // bench state
   stream_byte_type  send_q[$];
   frame_report_type report_q[$];
   stream_byte_type  launch;
   int unsigned      src_wait = 0;
   bit               src_calm = 1'b0;
   int unsigned      byte_count = 0;
   int unsigned      bytes_taken = 0;
   int unsigned      results_seen = 0;
   int unsigned      mismatches = 0;
   int unsigned      settings_run = 1;
   int unsigned      cycle_count = 0;
   int unsigned      ev_seen[8];
   int unsigned      sink_hold = 0;
   int unsigned      sink_draw;
   bit               sink_calm = 1'b0;
   frame_report_type want;
   rsp_fields_type   got;

   // frame tracker copy
   logic [7:0]       cfg_frame_type = 8'h00;
   track_phase_type  trk_phase = TRK_IDLE;
   logic             hold_special;
   logic [7:0]       hold_guide;
   logic [7:0]       hold_cmd;
   logic [AddrW-1:0] hold_addr;
   logic [7:0]       hold_data;
   logic [7:0]       hold_len;
   logic [7:0]       remaining;
   logic [7:0]       run_xor;

   function automatic void clear_holds();
      hold_special = 1'b0;
      hold_guide = 8'h00;
      hold_cmd = 8'h00;
      hold_addr = '0;
      hold_data = 8'h00;
      hold_len = 8'h00;
      remaining = 8'h00;
      run_xor = 8'h00;
   endfunction

   function automatic frame_report_type form_report(event_type ev, logic [7:0] dval,
                                                    logic [7:0] plen, logic check_ok);
      frame_report_type r;
      r.ev = ev;
      r.f.pad = '0;
      r.f.president = hold_cmd[CmdPresidentBit];
      r.f.initiative = hold_cmd[CmdInitiativeBit];
      r.f.endstation = hold_cmd[CmdEndstationBit];
      r.f.check_ok = check_ok;
      r.f.plen = plen;
      r.f.dval = dval;
      r.f.addr = hold_addr;
      r.f.command = hold_cmd;
      r.f.guide = hold_guide;
      return r;
   endfunction

   // advance the tracker by one accepted byte and queue the report it causes
   function automatic void deframe_byte(logic [7:0] b, logic sof, logic last);
      logic check_ok;
      if (sof) begin
         clear_holds();
         // wrong guide wins over truncation
         if (b != cfg_frame_type) begin
            trk_phase = TRK_IDLE;
            hold_guide = b;
            report_q.push_back(form_report(EV_WRONG_GUIDE, 8'h00, 8'h00, 1'b0));
            hold_guide = 8'h00;
            return;
         end
         hold_guide = b;
         run_xor = b;
         trk_phase = TRK_CMD;
      end else begin
         case (trk_phase)
            TRK_IDLE: return;
            TRK_CMD: begin
               hold_cmd = b;
               hold_special = (b[4:0] == SpecialMark);
               run_xor ^= b;
               trk_phase = TRK_ADDR_HI;
            end
            TRK_ADDR_HI: begin
               hold_addr = {b, 8'h00};
               run_xor ^= b;
               trk_phase = TRK_ADDR_LO;
            end
            TRK_ADDR_LO: begin
               hold_addr[7:0] = b;
               run_xor ^= b;
               trk_phase = hold_special ? TRK_LEN : TRK_DATA;
            end
            TRK_DATA: begin
               hold_data = b;
               run_xor ^= b;
               trk_phase = TRK_CHECK;
            end
            TRK_LEN: begin
               hold_len = b;
               remaining = b;
               run_xor ^= b;
               // zero length goes straight to the check byte
               trk_phase = (b != 8'h00) ? TRK_PAYLOAD : TRK_CHECK;
            end
            TRK_PAYLOAD: begin
               hold_data = b;
               run_xor ^= b;
               remaining = remaining - 8'd1;
               if (remaining == 8'h00) trk_phase = TRK_CHECK;
               if (!last) begin
                  report_q.push_back(form_report(EV_PAYLOAD, b, hold_len, 1'b0));
                  return;
               end
            end
            TRK_CHECK: begin
               check_ok = (run_xor == b);
               if (hold_special) begin
                  report_q.push_back(form_report(EV_SPECIAL_DONE, 8'h00, hold_len, check_ok));
               end else begin
                  report_q.push_back(form_report(EV_NORMAL_DONE, hold_data, 8'h00, check_ok));
               end
               trk_phase = TRK_IDLE;
               clear_holds();
               return;
            end
            default: return;
         endcase
      end
      // buffer ended before the frame did
      if (last) begin
         report_q.push_back(form_report(EV_TRUNCATED, hold_data, hold_len, 1'b0));
         trk_phase = TRK_IDLE;
         clear_holds();
      end
   endfunction

   function automatic void check_field(string name, int unsigned exp_val,
                                       int unsigned act_val);
      if (exp_val !== act_val) begin
         $error("%s expected %0h actual %0h", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   // byte stream driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_wait <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata, req_tuser, req_tlast);
            bytes_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_q.size() != 0 && src_wait >= send_q[0].gap) begin
               launch = send_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= launch.data;
               req_tuser <= launch.sof;
               req_tlast <= launch.last;
               src_wait <= 0;
            end else begin
               req_tvalid <= 1'b0;
               if (send_q.size() != 0) src_wait <= src_wait + 1;
            end
         end
      end
   end

   // result monitor with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (report_q.size() == 0) begin
            $error("result beat with no report pending: event %0d data %0h",
                   rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = report_q.pop_front();
            got = rsp_tdata;
            check_field("event_res", want.ev, rsp_tuser);
            check_field("guide_byte", want.f.guide, got.guide);
            check_field("command_byte", want.f.command, got.command);
            check_field("address", want.f.addr, got.addr);
            check_field("data_value", want.f.dval, got.dval);
            check_field("payload_length", want.f.plen, got.plen);
            check_field("checksum_ok", want.f.check_ok, got.check_ok);
            check_field("from_endstation", want.f.endstation, got.endstation);
            check_field("initiative", want.f.initiative, got.initiative);
            check_field("from_president", want.f.president, got.president);
            check_field("tdata pad", want.f.pad, got.pad);
            ev_seen[rsp_tuser]++;
            results_seen++;
         end
         if ($urandom_range(0, 24) == 0) sink_calm = !sink_calm;
         sink_draw = sink_calm ? 0 : $urandom_range(0, 6);
         sink_hold <= sink_draw;
         rsp_tready <= (sink_draw == 0);
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= (sink_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d reports pending", cycle_count,
                  report_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic sof, input logic last);
      stream_byte_type s;
      if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
      s.data = b;
      s.sof = sof;
      s.last = last;
      s.gap = src_calm ? 0 : $urandom_range(0, 6);
      send_q.push_back(s);
      byte_count++;
   endtask

   // one frame with the current guide; stop_at cuts it after that byte,
   // with or without a last mark there
   task automatic queue_frame(input bit special, input int unsigned plen, input bit good,
                              input int stop_at, input bit stop_last, input bit end_last);
      logic [7:0] fb[$];
      logic [7:0] cmd;
      logic [7:0] chk;
      logic [15:0] addr;
      int n;
      cmd = 8'($urandom);
      if (special) cmd[4:0] = SpecialMark;
      else if (cmd[4:0] == SpecialMark) cmd[0] = 1'b0;
      case ($urandom_range(0, 9))
         0: addr = 16'h0000;
         1: addr = 16'hffff;
         default: addr = 16'($urandom);
      endcase
      fb.push_back(cfg_frame_type);
      fb.push_back(cmd);
      fb.push_back(addr[15:8]);
      fb.push_back(addr[7:0]);
      if (special) begin
         fb.push_back(8'(plen));
         repeat (plen) fb.push_back(8'($urandom));
      end else begin
         fb.push_back(8'($urandom));
      end
      chk = 8'h00;
      foreach (fb[i]) chk ^= fb[i];
      if (!good) chk ^= 8'($urandom_range(1, 255));
      fb.push_back(chk);
      n = (stop_at < 0) ? fb.size() : stop_at + 1;
      for (int i = 0; i < n; i++) begin
         queue_byte(fb[i], i == 0, (i == n - 1) ? ((stop_at < 0) ? end_last : stop_last)
                                                : 1'b0);
      end
   endtask

   task automatic queue_random(input int unsigned quota);
      int unsigned start;
      int unsigned pick;
      int unsigned plen;
      int unsigned fsize;
      int unsigned r;
      bit special;
      start = byte_count;
      while (byte_count - start < quota) begin
         pick = $urandom_range(0, 99);
         special = $urandom_range(0, 1);
         r = $urandom_range(0, 99);
         plen = (r < 85) ? $urandom_range(0, 6) : (r < 99) ? $urandom_range(7, 40) : 255;
         fsize = special ? plen + 6 : 6;
         if (pick < 62) begin
            queue_frame(special, plen, $urandom_range(0, 4) != 0, -1, 1'b0,
                        $urandom_range(0, 1));
         end else if (pick < 74) begin
            // cut off by the end of the buffer
            queue_frame(special, plen, 1'b1, $urandom_range(0, fsize - 2), 1'b1, 1'b0);
         end else if (pick < 84) begin
            // abandoned, the next start mark restarts
            queue_frame(special, plen, 1'b1, $urandom_range(0, fsize - 2), 1'b0, 1'b0);
         end else if (pick < 91) begin
            queue_byte(cfg_frame_type ^ 8'($urandom_range(1, 255)), 1'b1,
                       $urandom_range(0, 1));
         end else begin
            repeat ($urandom_range(1, 3)) begin
               queue_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
            end
         end
      end
   endtask

   // wait until every byte is taken and every report has come back
   task automatic drain_stream();
      @(negedge clock);
      while (send_q.size() != 0 || req_tvalid || report_q.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_frame_type(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_frame_type = v;
      settings_run++;
   endtask

   // stimulus sequence
   initial begin
      logic [7:0] ft;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, guide value from reset is zero
      // frame restarted by a start mark after its command byte
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'h3f, 1'b0, 1'b0);
      // all zero normal frame, good check
      queue_byte(8'h00, 1'b1, 1'b0);
      repeat (5) queue_byte(8'h00, 1'b0, 1'b0);
      // stray byte while idle
      queue_byte(8'hff, 1'b0, 1'b0);
      // wrong guide together with last mark
      queue_byte(8'hff, 1'b1, 1'b1);
      // zero length special frame, all flags set, bad check
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'hff, 1'b0, 1'b0);
      queue_byte(8'hff, 1'b0, 1'b0);
      queue_byte(8'hff, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'haa, 1'b0, 1'b0);
      // special frame cut on its only payload byte
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'h3f, 1'b0, 1'b0);
      queue_byte(8'h12, 1'b0, 1'b0);
      queue_byte(8'h34, 1'b0, 1'b0);
      queue_byte(8'h01, 1'b0, 1'b0);
      queue_byte(8'h5a, 1'b0, 1'b1);
      // buffer ends on the guide byte
      queue_byte(8'h00, 1'b1, 1'b1);
      queue_random(PhaseBytes);
      drain_stream();

      for (int i = 0; i < 5; i++) begin
         case (i)
            0: ft = 8'hff;
            1: ft = 8'h00;
            3: ft = 8'h80;
            default: ft = 8'($urandom);
         endcase
         write_frame_type(ft);
         @(negedge clock);
         queue_random(PhaseBytes);
         drain_stream();
      end

      $display("checked %0d results from %0d bytes over %0d guide settings",
               results_seen, bytes_taken, settings_run);
      $display("normal %0d, payload %0d, special %0d, wrong guide %0d, truncated %0d",
               ev_seen[EV_NORMAL_DONE], ev_seen[EV_PAYLOAD], ev_seen[EV_SPECIAL_DONE],
               ev_seen[EV_WRONG_GUIDE], ev_seen[EV_TRUNCATED]);
      if (mismatches == 0 && report_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule : conference_frame_deframer_core_test

// ----- conference_frame_deframer_core.f -----
sv/cfd_pkg.sv
sv/conference_frame_deframer_core.sv
dv/conference_frame_deframer_core_test.sv
